[rtl/core/bsm_pkg.sv]
package bsm_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadiusW = 31;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned SqW     = 68;
  localparam int unsigned RootW   = 34;
  localparam int unsigned ProdW   = 66;

  localparam logic signed [CoordW-1:0] CenterMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CenterMin = 32'sh8000_0000;
  localparam logic [RadiusW-1:0] RadiusMax = 31'h7FFF_FFFF;

  // operation codes for the shared unit
  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_DIV  = 2'd1
  } bsm_op_e;

  // request and status between the sequencer and the shared unit
  typedef struct packed {
    logic            start;
    bsm_op_e         op;
    logic [ProdW-1:0] num;
    logic [RootW-1:0] den;
  } bsm_unit_req_t;

  typedef struct packed {
    logic            done;
    logic [ProdW-1:0] result;
  } bsm_unit_rsp_t;

endpackage

[rtl/core/bounding_sphere_merge_core.sv]
// Running bounding sphere of a stream of Q16.16 spheres. Every accepted request
// answers with one result, the running sphere after the update. A start request
// (or the first after reset) loads the sphere directly; a merge takes a 32-bit
// square per axis and a 34-step square root, and when the center moves, per axis
// a 32x34 multiply, a 66-step long division and the update, all on one shared
// sqrt/divide unit.
// in_stall_o is high while an item is in work or its result waits.
module bounding_sphere_merge_core
  import bsm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [CoordW-1:0]  center_x_i,
  input  logic signed [CoordW-1:0]  center_y_i,
  input  logic signed [CoordW-1:0]  center_z_i,
  input  logic [RadiusW-1:0]        radius_i,
  input  logic                      start_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [CoordW-1:0]  out_center_x_o,
  output logic signed [CoordW-1:0]  out_center_y_o,
  output logic signed [CoordW-1:0]  out_center_z_o,
  output logic [RadiusW-1:0]        out_radius_o
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_DIFF  = 10'b00_0000_0010,
    ST_SQ    = 10'b00_0000_0100,
    ST_SQRT  = 10'b00_0000_1000,
    ST_CMP   = 10'b00_0001_0000,
    ST_MUL   = 10'b00_0010_0000,
    ST_DIV   = 10'b00_0100_0000,
    ST_MOVE  = 10'b00_1000_0000,
    ST_OUT   = 10'b01_0000_0000,
    ST_WAIT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   rvalid_q;
  logic   out_valid_q;
  logic [1:0] axis_q;
  logic   sq_go_q;
  logic   start_q;
  logic   merge_move;

  logic signed [CoordW-1:0] rc_q [3];
  logic [RadiusW-1:0]       rr_q;
  logic signed [CoordW-1:0] ic_q [3];
  logic [RadiusW-1:0]       ir_q;
  logic signed [DiffW-1:0]  d_q [3];
  logic [SqW-1:0]           acc_q;
  logic [RootW-1:0]         dist_q;
  logic [RootW-1:0]         k_q;

  bsm_unit_req_t unit_req;
  bsm_unit_rsp_t unit_rsp;

  bsm_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  logic signed [DiffW-1:0] d_cur;
  logic signed [DiffW-1:0] d_neg;
  logic [DiffW-2:0] mag_cur;
  logic [RootW-1:0] mul_b;
  logic [ProdW-1:0] mul_out;
  logic [RootW+1:0] sum_ri;
  logic [RootW+1:0] sum_ir;
  logic [RootW+1:0] nr_full;
  logic [RootW+1:0] nr_half;
  logic signed [RootW+1:0] step_s;
  logic signed [RootW+1:0] moved;

  // shared magnitude and multiplier (offset magnitudes fit 32 bits)
  always_comb begin
    d_cur   = d_q[axis_q];
    d_neg   = -d_cur;
    mag_cur = d_cur[DiffW-1] ? d_neg[DiffW-2:0] : d_cur[DiffW-2:0];
    mul_b   = (state_q == ST_SQ) ? RootW'(mag_cur) : k_q;
    mul_out = ProdW'(mag_cur) * ProdW'(mul_b);
  end

  always_comb begin
    sum_ri  = (RootW+2)'(dist_q) + (RootW+2)'(ir_q);
    sum_ir  = (RootW+2)'(dist_q) + (RootW+2)'(rr_q);
    nr_full = sum_ri + (RootW+2)'(rr_q);
    nr_half = nr_full >> 1;
    step_s  = (RootW+2)'(unit_rsp.result[RootW-1:0]);
    moved   = d_q[axis_q][DiffW-1] ? (RootW+2)'(rc_q[axis_q]) - step_s
                                  : (RootW+2)'(rc_q[axis_q]) + step_s;
  end

  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = OP_SQRT;
    unit_req.num   = ProdW'(acc_q);
    unit_req.den   = dist_q;
    if (state_q == ST_SQ && axis_q == 2'd3) begin
      unit_req.start = 1'b1;
    end else if (state_q == ST_MUL && sq_go_q) begin
      unit_req.start = 1'b1;
      unit_req.op    = OP_DIV;
      unit_req.num   = mul_out;
    end
  end

  assign merge_move = !((RootW+2)'(rr_q) >= sum_ri) && !((RootW+2)'(ir_q) >= sum_ir)
                      && (dist_q > RootW'(1));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_DIFF;
      ST_DIFF: state_d = (start_q || !rvalid_q) ? ST_OUT : ST_SQ;
      ST_SQ:   if (axis_q == 2'd3) state_d = ST_SQRT;
      ST_SQRT: if (unit_rsp.done) state_d = ST_CMP;
      ST_CMP:  state_d = ST_OUT;
      ST_MUL:  if (sq_go_q) state_d = ST_DIV;
      ST_DIV:  if (unit_rsp.done) state_d = ST_MOVE;
      ST_MOVE: state_d = (axis_q == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT:  state_d = ST_WAIT;
      ST_WAIT: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_CMP && merge_move) state_d = ST_MUL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      axis_q      <= '0;
      sq_go_q     <= 1'b0;
      for (int i = 0; i < 3; i++) rc_q[i] <= '0;
      rr_q        <= '0;
    end else begin
      state_q <= state_d;
      sq_go_q <= 1'b0;
      case (state_q)
        ST_DIFF: begin
          axis_q <= '0;
          if (start_q || !rvalid_q) begin
            for (int i = 0; i < 3; i++) rc_q[i] <= ic_q[i];
            rr_q     <= ir_q;
            rvalid_q <= 1'b1;
          end
        end
        ST_SQ: if (axis_q != 2'd3) axis_q <= axis_q + 2'd1;
        ST_CMP: begin
          axis_q  <= '0;
          sq_go_q <= 1'b1;
          if ((RootW+2)'(rr_q) >= sum_ri) begin
          end else if ((RootW+2)'(ir_q) >= sum_ir) begin
            for (int i = 0; i < 3; i++) rc_q[i] <= ic_q[i];
            rr_q <= ir_q;
          end else begin
            rr_q <= (nr_half > (RootW+2)'(RadiusMax)) ? RadiusMax
                                                    : nr_half[RadiusW-1:0];
          end
        end
        ST_MOVE: begin
          if (moved > (RootW+2)'(CenterMax)) rc_q[axis_q] <= CenterMax;
          else if (moved < (RootW+2)'(CenterMin)) rc_q[axis_q] <= CenterMin;
          else rc_q[axis_q] <= moved[CoordW-1:0];
          axis_q  <= axis_q + 2'd1;
          sq_go_q <= 1'b1;
        end
        default: ;
      endcase
      if (state_q == ST_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ic_q[0] <= center_x_i;
      ic_q[1] <= center_y_i;
      ic_q[2] <= center_z_i;
      ir_q    <= radius_i;
      start_q <= start_req_i;
    end
    case (state_q)
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) d_q[i] <= DiffW'(ic_q[i]) - DiffW'(rc_q[i]);
        acc_q <= '0;
      end
      ST_SQ: if (axis_q != 2'd3) acc_q <= acc_q + SqW'(mul_out);
      ST_SQRT: if (unit_rsp.done) dist_q <= unit_rsp.result[RootW-1:0];
      ST_CMP: k_q <= RootW'(nr_half - (RootW+2)'(rr_q));
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign out_center_x_o = rc_q[0];
  assign out_center_y_o = rc_q[1];
  assign out_center_z_o = rc_q[2];
  assign out_radius_o   = rr_q;

endmodule

[rtl/core/bsm_iter_unit.sv]
// shared iterative unit: restoring square root (2 bits a cycle) or long division
// (1 bit a cycle)
module bsm_iter_unit
  import bsm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bsm_unit_req_t req_i,
  output bsm_unit_rsp_t rsp_o
);

  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] SqrtSteps = 7'd34;
  localparam logic [CntW-1:0] DivSteps  = 7'd66;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  bsm_op_e          op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SqW-1:0]   src_q, src_d;
  logic [RootW+1:0] rem_q, rem_d;
  logic [ProdW-1:0] res_q, res_d;
  logic [RootW-1:0] den_q, den_d;

  logic [RootW+1:0] sq_rem;
  logic [RootW+1:0] sq_trial;
  logic [RootW+1:0] dv_rem;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    src_d  = src_q;
    rem_d  = rem_q;
    res_d  = res_q;
    den_d  = den_q;
    sq_rem   = {rem_q[RootW-1:0], src_q[SqW-1 -: 2]};
    sq_trial = {res_q[RootW-1:0], 2'b01};
    dv_rem   = {rem_q[RootW:0], src_q[SqW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == OP_SQRT) ? SqrtSteps : DivSteps;
      src_d  = (req_i.op == OP_SQRT) ? SqW'(req_i.num)
                                     : {req_i.num, 2'b00};
      rem_d  = '0;
      res_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      case (op_q)
        OP_SQRT: begin
          src_d = {src_q[SqW-3:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            rem_d = sq_rem - sq_trial;
            res_d = {res_q[ProdW-2:0], 1'b1};
          end else begin
            rem_d = sq_rem;
            res_d = {res_q[ProdW-2:0], 1'b0};
          end
        end
        OP_DIV: begin
          src_d = {src_q[SqW-2:0], 1'b0};
          if (dv_rem >= {2'b00, den_q}) begin
            rem_d = dv_rem - {2'b00, den_q};
            res_d = {res_q[ProdW-2:0], 1'b1};
          end else begin
            rem_d = dv_rem;
            res_d = {res_q[ProdW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    rem_q <= rem_d;
    res_q <= res_d;
    den_q <= den_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

[verif/bounding_sphere_merge_core_tb.sv]
`timescale 1ns / 100ps

module bounding_sphere_merge_core_tb
  import bsm_pkg::*;
();

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [RadiusW-1:0] r;
  } sphere_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [CoordW-1:0] center_x_i;
  logic signed [CoordW-1:0] center_y_i;
  logic signed [CoordW-1:0] center_z_i;
  logic [RadiusW-1:0] radius_i;
  logic start_req_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [CoordW-1:0] out_center_x_o;
  logic signed [CoordW-1:0] out_center_y_o;
  logic signed [CoordW-1:0] out_center_z_o;
  logic [RadiusW-1:0] out_radius_o;

  bounding_sphere_merge_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .center_x_i(center_x_i), .center_y_i(center_y_i), .center_z_i(center_z_i),
    .radius_i(radius_i), .start_req_i(start_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_center_x_o(out_center_x_o), .out_center_y_o(out_center_y_o),
    .out_center_z_o(out_center_z_o), .out_radius_o(out_radius_o)
  );

  // running sphere as predicted
  logic signed [63:0] run_x, run_y, run_z, run_r;
  logic run_live;
  sphere_t expected_spheres[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit hold_off;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned quiet_cycles;
  bit watchdog_hit;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [63:0] clamp_center(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor sqrt of a 68-bit value, bit by bit
  function automatic logic [33:0] floor_root(logic [67:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rem = '0;
    root = '0;
    for (int g = 33; g >= 0; g--) begin
      rem = (rem << 2) | 68'(v[2*g +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [63:0] shift_axis(logic signed [63:0] base,
      logic signed [63:0] off, logic [63:0] k, logic [63:0] span);
    logic [127:0] prod;
    logic [63:0] mag_off;
    logic signed [63:0] step;
    mag_off = off < 0 ? 64'(-off) : 64'(off);
    prod = 128'(mag_off) * 128'(k);
    step = 64'((prod / 128'(span)) & 128'h3_FFFF_FFFF);
    return clamp_center(off < 0 ? base - step : base + step);
  endfunction

  // update the running sphere with one request, queue the answer
  task automatic merge_sphere(logic signed [31:0] cx, logic signed [31:0] cy,
      logic signed [31:0] cz, logic [30:0] r, logic st);
    logic signed [63:0] dx, dy, dz, span, lr, rr, nr;
    logic [67:0] ax, ay, az;
    logic [67:0] sq;
    sphere_t s;
    rr = 64'(r);
    if (st || !run_live) begin
      run_x = cx; run_y = cy; run_z = cz; run_r = rr; run_live = 1'b1;
    end else begin
      dx = 64'(cx) - run_x;
      dy = 64'(cy) - run_y;
      dz = 64'(cz) - run_z;
      ax = 68'(dx < 0 ? -dx : dx);
      ay = 68'(dy < 0 ? -dy : dy);
      az = 68'(dz < 0 ? -dz : dz);
      sq = ax * ax + ay * ay + az * az;
      span = 64'(floor_root(sq));
      lr = run_r;
      if (lr >= span + rr) begin
      end else if (rr >= span + lr) begin
        run_x = cx; run_y = cy; run_z = cz; run_r = rr;
      end else begin
        nr = (span + lr + rr) >>> 1;
        if (span > 1) begin
          run_x = shift_axis(run_x, dx, 64'(nr - lr), 64'(span));
          run_y = shift_axis(run_y, dy, 64'(nr - lr), 64'(span));
          run_z = shift_axis(run_z, dz, 64'(nr - lr), 64'(span));
        end
        run_r = nr > 64'sd2147483647 ? 64'sd2147483647 : nr;
      end
    end
    s.cx = run_x[31:0]; s.cy = run_y[31:0]; s.cz = run_z[31:0]; s.r = run_r[30:0];
    expected_spheres.insert(expected_spheres.size(), s);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s at result %0d: got %h want %h", what, results_checked, got,
             want);
    mismatches++;
  endtask

  // offer one request, wait for acceptance
  task automatic send_sphere(logic signed [31:0] cx, logic signed [31:0] cy,
      logic signed [31:0] cz, logic [30:0] r, logic st);
    @(posedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    center_x_i <= cx; center_y_i <= cy; center_z_i <= cz;
    radius_i <= r; start_req_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    merge_sphere(cx, cy, cz, r, st);
    requests_sent++;
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int unsigned spread);
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * spread, 0)) - $signed(spread));
      default: return 32'($signed($urandom_range(8000000, 0)) - 4000000);
    endcase
  endfunction

  // receiver stall and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_spheres.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          sphere_t w;
          w = expected_spheres.pop_front();
          if (out_center_x_o !== w.cx) report_mismatch("center_x", out_center_x_o, w.cx);
          if (out_center_y_o !== w.cy) report_mismatch("center_y", out_center_y_o, w.cy);
          if (out_center_z_o !== w.cz) report_mismatch("center_z", out_center_z_o, w.cz);
          if (out_radius_o !== w.r) report_mismatch("radius", {1'b0, out_radius_o},
                                                    {1'b0, w.r});
        end
        results_checked++;
      end
      out_stall_i <= hold_off || ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit && !watchdog_hit) begin
      watchdog_hit = 1'b1;
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("bounding_sphere_merge_core regression: fail");
      $finish;
    end
  end

  // extremes, containment, coincident centers, saturation
  task automatic test_directed();
    send_sphere(32'sd0, 32'sd0, 32'sd0, 31'd65536, 1'b0);
    send_sphere(32'sd0, 32'sd0, 32'sd0, 31'd100, 1'b0);
    send_sphere(32'sd1, 32'sd0, 32'sd0, 31'd65536, 1'b0);
    send_sphere(32'sd1, 32'sd0, 32'sd0, 31'd70000, 1'b0);
    send_sphere(32'sd0, 32'sd1, 32'sd0, 31'd80000, 1'b0);
    send_sphere(32'sd0, 32'sd0, 32'sd1, 31'd1, 1'b0);
    send_sphere(32'sd1000000, -32'sd500000, 32'sd250000, 31'd1000, 1'b0);
    send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
    send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 1'b0);
    send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 1'b1);
    send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0, 1'b0);
    send_sphere(32'sd0, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 1'b1);
    send_sphere(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 1'b0);
    send_sphere(-32'sd1, -32'sd1, -32'sd1, 31'h5555_5555, 1'b1);
    send_sphere(32'sd200000, 32'sd0, 32'sd0, 31'd10, 1'b0);
    send_sphere(-32'sd200000, 32'sd0, 32'sd0, 31'd10, 1'b0);
  endtask

  // runs of merges with random content, restarts now and then
  task automatic test_random(int unsigned count);
    int unsigned spread;
    for (int unsigned i = 0; i < count; i++) begin
      spread = ($urandom_range(9, 0) == 0) ? 32'h7FFF_FFFF : 1 << $urandom_range(30, 4);
      send_sphere(rand_coord(spread), rand_coord(spread), rand_coord(spread),
                  ($urandom_range(7, 0) == 0) ? 31'($urandom())
                                              : 31'($urandom_range(spread >> 1, 0)),
                  $urandom_range(15, 0) == 0);
    end
  endtask

  // receiver holds off long while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(12);
    join
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    center_x_i = '0; center_y_i = '0; center_z_i = '0;
    radius_i = '0; start_req_i = 1'b0;
    out_stall_i = 1'b0;
    hold_off = 1'b0;
    run_x = 0; run_y = 0; run_z = 0; run_r = 0; run_live = 1'b0;
    mismatches = 0; requests_sent = 0; results_checked = 0;
    quiet_cycles = 0; watchdog_hit = 1'b0;
    send_idle_pct = 11; recv_idle_pct = 75;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(550);
    send_idle_pct = 75; recv_idle_pct = 11;
    test_random(530);
    test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(540);

    while (expected_spheres.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d requests and %0d results: starts, containment, merges,",
             requests_sent, results_checked);
    $display("saturation, coincident centers, idle mixes and a long receiver hold-off");
    if (mismatches == 0 && expected_spheres.size() == 0)
      $display("bounding_sphere_merge_core regression: pass");
    else
      $display("bounding_sphere_merge_core regression: fail");
    $finish;
  end

endmodule
